@@ hw/rtl/magic_packet_filter_dedup_assert.svh @@
// assertion macros for the magic packet filter
// expects clk_i and rst_ni in the scope of every use
`ifndef MAGIC_PACKET_FILTER_DEDUP_ASSERT_SVH
`define MAGIC_PACKET_FILTER_DEDUP_ASSERT_SVH

// same-cycle implication
`define MPFD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mpfd assertion failed");

// next-cycle implication
`define MPFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mpfd assertion failed");

`endif

@@ hw/rtl/mpfd_pkg.sv @@
// shared types and constants of the magic packet filter
// used by mpfd_parse, mpfd_walk and magic_packet_filter_dedup
package mpfd_pkg;

  localparam int unsigned PosW       = 7;
  localparam int unsigned MacW       = 48;
  localparam int unsigned AddrW      = 32;
  localparam int unsigned SecW       = 32;
  localparam int unsigned WinW       = 8;
  localparam int unsigned SyncBytes  = 6;
  localparam int unsigned MacBytes   = 6;
  localparam int unsigned MacRepeats = 16;
  localparam int unsigned MagicLen   = SyncBytes + MacBytes * MacRepeats;

  localparam logic [PosW-1:0] SyncEnd    = PosW'(SyncBytes);
  localparam logic [PosW-1:0] CaptureEnd = PosW'(SyncBytes + MacBytes);
  localparam logic [PosW-1:0] MagicEnd   = PosW'(MagicLen);
  localparam logic [2:0]      LastMacIdx = 3'(MacBytes - 1);
  localparam logic [7:0]      SyncByte   = 8'hFF;
  localparam logic [WinW-1:0] WindowReset = 8'd5;

  typedef enum logic [1:0] {
    VERDICT_RELAY     = 2'd0,
    VERDICT_SOURCE    = 2'd1,
    VERDICT_NOT_MAGIC = 2'd2,
    VERDICT_DUPLICATE = 2'd3
  } verdict_e;

  typedef enum logic [1:0] {
    CFG_ALLOW_ADDRESS  = 2'd0,
    CFG_ALLOW_NETMASK  = 2'd1,
    CFG_WINDOW_SECONDS = 2'd2
  } cfg_idx_e;

  // one table entry as stored in the ram
  typedef struct packed {
    logic [AddrW-1:0] src;
    logic [MacW-1:0]  mac;
    logic [SecW-1:0]  stamp;
  } entry_t;

  typedef struct packed {
    logic             magic_ok;
    logic [MacW-1:0]  mac;
  } parse_st_t;

  typedef struct packed {
    logic             start;
    logic [AddrW-1:0] src;
    logic [MacW-1:0]  mac;
    logic [SecW-1:0]  seconds;
    logic [WinW-1:0]  window;
  } walk_req_t;

  typedef struct packed {
    logic done;
    logic dup;
  } walk_rsp_t;

endpackage

@@ hw/rtl/mpfd_ram.sv @@
// generic simple dual port ram, one write and one registered read port
// no dependencies
module mpfd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/mpfd_parse.sv @@
// payload byte tracker: sync bytes, mac capture and repeat compare
// depends on mpfd_pkg
module mpfd_parse (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  take_i,
  input  logic [7:0]            byte_i,
  input  logic                  clear_i,
  output mpfd_pkg::parse_st_t   st_o
);

  logic [mpfd_pkg::PosW-1:0] pos_q, pos_d;
  logic [2:0]                k_q, k_d;
  logic [mpfd_pkg::MacW-1:0] mac_q, mac_d;
  logic                      broken_q, broken_d;
  logic [7:0]                want;

  // byte of the captured mac expected at this place of the repeat
  always_comb begin
    case (k_q)
      3'd0:    want = mac_q[47:40];
      3'd1:    want = mac_q[39:32];
      3'd2:    want = mac_q[31:24];
      3'd3:    want = mac_q[23:16];
      3'd4:    want = mac_q[15:8];
      3'd5:    want = mac_q[7:0];
      default: want = 8'h00;
    endcase
  end

  always_comb begin
    pos_d    = pos_q;
    k_d      = k_q;
    mac_d    = mac_q;
    broken_d = broken_q;
    if (clear_i) begin
      pos_d    = '0;
      k_d      = '0;
      mac_d    = '0;
      broken_d = 1'b0;
    end else if (take_i && (pos_q < mpfd_pkg::MagicEnd)) begin
      if (pos_q < mpfd_pkg::SyncEnd) begin
        if (byte_i != mpfd_pkg::SyncByte) begin
          broken_d = 1'b1;
        end
      end else if (pos_q < mpfd_pkg::CaptureEnd) begin
        mac_d = {mac_q[mpfd_pkg::MacW-9:0], byte_i};
      end else if (byte_i != want) begin
        broken_d = 1'b1;
      end
      if (pos_q >= mpfd_pkg::SyncEnd) begin
        k_d = (k_q == mpfd_pkg::LastMacIdx) ? 3'd0 : k_q + 3'd1;
      end
      pos_d = pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      k_q      <= '0;
      mac_q    <= '0;
      broken_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      k_q      <= k_d;
      mac_q    <= mac_d;
      broken_q <= broken_d;
    end
  end

  assign st_o.magic_ok = (pos_q == mpfd_pkg::MagicEnd) && !broken_q;
  assign st_o.mac      = mac_q;

endmodule

@@ hw/rtl/mpfd_walk.sv @@
// duplicate table walker: one ram read and one compare per entry through a shared compare unit
// depends on mpfd_pkg and mpfd_ram
module mpfd_walk #(
  parameter int unsigned Entries = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mpfd_pkg::walk_req_t req_i,
  output mpfd_pkg::walk_rsp_t rsp_o
);

  localparam int unsigned IdxW   = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned EntryW = $bits(mpfd_pkg::entry_t);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Entries - 1);

  typedef enum logic [3:0] {
    W_IDLE  = 4'b0001,
    W_READ  = 4'b0010,
    W_CMP   = 4'b0100,
    W_WRITE = 4'b1000
  } walk_state_e;

  walk_state_e               state_q, state_d;
  logic [IdxW-1:0]           idx_q, idx_d;
  logic [IdxW-1:0]           victim_q, victim_d;
  logic [mpfd_pkg::SecW-1:0] victim_age_q, victim_age_d;
  logic                      have_empty_q, have_empty_d;
  logic [Entries-1:0]        valid_q;

  logic                      ram_we, ram_re;
  logic [EntryW-1:0]         rd_data;
  mpfd_pkg::entry_t          rd_entry, wr_entry;
  logic [mpfd_pkg::SecW-1:0] age;
  logic                      hit, take_valid, take_empty;

  assign wr_entry.src   = req_i.src;
  assign wr_entry.mac   = req_i.mac;
  assign wr_entry.stamp = req_i.seconds;

  mpfd_ram #(
    .Width (EntryW),
    .Depth (Entries)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (victim_q),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (rd_data)
  );

  assign rd_entry = mpfd_pkg::entry_t'(rd_data);

  // shared unit: age subtract, match compare, victim compare
  assign age = req_i.seconds - rd_entry.stamp;
  assign hit = valid_q[idx_q] && (rd_entry.src == req_i.src) &&
               (rd_entry.mac == req_i.mac) &&
               (age < {{(mpfd_pkg::SecW - mpfd_pkg::WinW){1'b0}}, req_i.window});
  assign take_valid = valid_q[idx_q] && !have_empty_q &&
                      ((idx_q == '0) || (age > victim_age_q));
  assign take_empty = !valid_q[idx_q] && !have_empty_q;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    victim_d     = victim_q;
    victim_age_d = victim_age_q;
    have_empty_d = have_empty_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    rsp_o.done   = 1'b0;
    rsp_o.dup    = 1'b0;
    unique case (state_q)
      W_IDLE: begin
        if (req_i.start) begin
          idx_d        = '0;
          victim_d     = '0;
          victim_age_d = '0;
          have_empty_d = 1'b0;
          state_d      = W_READ;
        end
      end
      W_READ: begin
        ram_re  = 1'b1;
        state_d = W_CMP;
      end
      W_CMP: begin
        if (hit) begin
          rsp_o.done = 1'b1;
          rsp_o.dup  = 1'b1;
          state_d    = W_IDLE;
        end else begin
          if (take_valid) begin
            victim_d     = idx_q;
            victim_age_d = age;
          end
          if (take_empty) begin
            have_empty_d = 1'b1;
            victim_d     = idx_q;
          end
          if (idx_q == LastIdx) begin
            state_d = W_WRITE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = W_READ;
          end
        end
      end
      W_WRITE: begin
        ram_we     = 1'b1;
        rsp_o.done = 1'b1;
        state_d    = W_IDLE;
      end
      default: state_d = W_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= W_IDLE;
      idx_q        <= '0;
      victim_q     <= '0;
      victim_age_q <= '0;
      have_empty_q <= 1'b0;
      valid_q      <= '0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      victim_q     <= victim_d;
      victim_age_q <= victim_age_d;
      have_empty_q <= have_empty_d;
      if (state_q == W_WRITE) begin
        valid_q[victim_q] <= 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/magic_packet_filter_dedup.sv @@
// wake-on-lan magic packet filter with source allow mask and duplicate table
// payload bytes and ticks are taken only while idle; a refused final byte goes from
// the eval state straight to the result, else the verdict waits on the walk of the table ram
// (one read and one shared compare per entry), which ends early when a duplicate is found
// reset sets config to its defaults and clears the time base and all table valid bits at once; no clearing pass
// depends on mpfd_pkg, mpfd_parse, mpfd_walk and the assertion header
module magic_packet_filter_dedup #(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [31:0] source_ip_i,
  // result request channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  verdict_o,
  output logic [47:0] mac_address_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

`include "magic_packet_filter_dedup_assert.svh"

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EVAL = 4'b0010,
    ST_WALK = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e                     state_q, state_d;

  // configuration registers
  logic [mpfd_pkg::AddrW-1:0] allow_address_q;
  logic [mpfd_pkg::AddrW-1:0] allow_netmask_q;
  logic [mpfd_pkg::WinW-1:0]  window_seconds_q;

  // time base, advanced by tick requests
  logic [mpfd_pkg::SecW-1:0]  seconds_q;

  // per-packet result being built
  logic [mpfd_pkg::AddrW-1:0] src_q, src_d;
  logic [mpfd_pkg::MacW-1:0]  res_mac_q, res_mac_d;
  mpfd_pkg::verdict_e         res_verdict_q, res_verdict_d;

  // output register, decouples the result side from the input side
  logic                       out_valid_q, out_valid_d;
  logic [1:0]                 out_verdict_q;
  logic [mpfd_pkg::MacW-1:0]  out_mac_q;

  logic                       in_fire, byte_fire, tick_fire, last_fire;
  logic                       src_fail, emit_fire;
  mpfd_pkg::parse_st_t        parse_st;
  mpfd_pkg::walk_req_t        walk_req;
  mpfd_pkg::walk_rsp_t        walk_rsp;

  // only the idle state takes requests; a pending result does not block bytes
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign tick_fire  = in_fire && mode_i;
  assign byte_fire  = in_fire && !mode_i;
  assign last_fire  = byte_fire && last_byte_i;

  assign cfg_ready_o = 1'b1;

  // source check under the netmask; a zero mask lets every source through
  assign src_fail = ((src_q ^ allow_address_q) & allow_netmask_q) != '0;

  // the result register is free, or is being drained this cycle
  assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);

  mpfd_parse u_parse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (byte_fire),
    .byte_i  (data_byte_i),
    .clear_i (state_q == ST_EVAL),
    .st_o    (parse_st)
  );

  // the walker reads src and mac from registers held through the walk
  assign walk_req.start   = (state_q == ST_EVAL) && !src_fail && parse_st.magic_ok;
  assign walk_req.src     = src_q;
  assign walk_req.mac     = res_mac_q;
  assign walk_req.seconds = seconds_q;
  assign walk_req.window  = window_seconds_q;

  mpfd_walk #(
    .Entries (TABLE_ENTRIES)
  ) u_walk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (walk_req),
    .rsp_o  (walk_rsp)
  );

  // packet sequencer
  always_comb begin
    state_d       = state_q;
    src_d         = src_q;
    res_mac_d     = res_mac_q;
    res_verdict_d = res_verdict_q;
    unique case (state_q)
      ST_IDLE: begin
        // the parser already takes the final byte this cycle
        if (last_fire) begin
          src_d   = source_ip_i;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        // check order: source, then magic pattern, then the table
        if (src_fail) begin
          res_verdict_d = mpfd_pkg::VERDICT_SOURCE;
          res_mac_d     = '0;
          state_d       = ST_EMIT;
        end else if (!parse_st.magic_ok) begin
          res_verdict_d = mpfd_pkg::VERDICT_NOT_MAGIC;
          res_mac_d     = '0;
          state_d       = ST_EMIT;
        end else begin
          res_mac_d = parse_st.mac;
          state_d   = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_rsp.done) begin
          res_verdict_d = walk_rsp.dup ? mpfd_pkg::VERDICT_DUPLICATE
                                       : mpfd_pkg::VERDICT_RELAY;
          state_d       = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_fire) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      out_valid_q      <= 1'b0;
      seconds_q        <= '0;
      allow_address_q  <= '0;
      allow_netmask_q  <= '0;
      window_seconds_q <= mpfd_pkg::WindowReset;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (tick_fire) begin
        seconds_q <= seconds_q + 1'b1;
      end
      // writes to an index past the register list are dropped
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          mpfd_pkg::CFG_ALLOW_ADDRESS:  allow_address_q  <= cfg_data_i;
          mpfd_pkg::CFG_ALLOW_NETMASK:  allow_netmask_q  <= cfg_data_i;
          mpfd_pkg::CFG_WINDOW_SECONDS: window_seconds_q <= cfg_data_i[mpfd_pkg::WinW-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers, qualified by the control state above
  always_ff @(posedge clk_i) begin
    src_q         <= src_d;
    res_mac_q     <= res_mac_d;
    res_verdict_q <= res_verdict_d;
    if (emit_fire) begin
      out_verdict_q <= res_verdict_q;
      out_mac_q     <= res_mac_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign verdict_o     = out_verdict_q;
  assign mac_address_o = out_mac_q;

  // the walker answers only while the sequencer waits on it
  `MPFD_ASSERT_NOW(a_walk_done_in_walk, walk_rsp.done, state_q == ST_WALK)
  // a refused source goes straight to the result with its verdict
  `MPFD_ASSERT_NEXT(a_source_refused, (state_q == ST_EVAL) && src_fail,
                    (state_q == ST_EMIT) && (res_verdict_q == mpfd_pkg::VERDICT_SOURCE))
  // refused packets carry no mac
  `MPFD_ASSERT_NOW(a_refused_mac_zero,
                   out_valid_o && ((verdict_o == mpfd_pkg::VERDICT_SOURCE) ||
                   (verdict_o == mpfd_pkg::VERDICT_NOT_MAGIC)),
                   mac_address_o == '0)
  // a tick request moves the time base by exactly one
  `MPFD_ASSERT_NEXT(a_tick_advances, tick_fire, seconds_q == $past(seconds_q) + 1'b1)

endmodule
